>>> sv/lepp_pkg.sv
// Shared types, constants and helpers of the lane edge point projector.
package lepp_pkg;

    localparam int MAP_WIDTH_DEF   = 640;
    localparam int MAP_HEIGHT_DEF  = 480;
    localparam int NUM_CLASSES_DEF = 13;

    localparam int CFG_W   = 63;
    localparam int CFG_IDX_W = 3;
    localparam int COEF_W  = 21;

    localparam logic [CFG_IDX_W-1:0] REG_HOM0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOM1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOM2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAXFWD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MINPTS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROIW    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ROIH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROIS    = 3'd7;

    localparam logic [14:0] MAXFWD_RST = 15'd19200;
    localparam logic [7:0]  MINPTS_RST = 8'd2;
    localparam logic [11:0] ROIW_RST   = 12'd1920;
    localparam logic [11:0] ROIH_RST   = 12'd768;
    localparam logic [11:0] ROIS_RST   = 12'd312;

    localparam logic signed [15:0] FWD_NEAR  = 16'sd3200;
    localparam logic signed [12:0] LAT_LIMIT = 13'sd1920;
    localparam logic [12:0]        LAT_STEP  = 13'd64;

    // Front-to-back queue entry.
    typedef struct packed {
        logic        frame_start;
        logic        edge_ok;
        logic [3:0]  label;
        logic [9:0]  col;
        logic [9:0]  row;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCALE, ST_PROJ, ST_DIV, ST_CHECK, ST_OUT
    } t_state;

    function automatic logic signed [COEF_W-1:0] coef(input logic [CFG_W-1:0] r,
                                                      input int k);
        coef = r[COEF_W*k +: COEF_W];
    endfunction

endpackage

>>> sv/lepp_front.sv
// Front part: accept pixels, run the edge test, push into a short queue.
module lepp_front #(
    parameter int NUM_CLASSES = lepp_pkg::NUM_CLASSES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_frame_start,
    input  logic [3:0]           i_label,
    input  logic [3:0]           i_left_label,
    input  logic [3:0]           i_right_label,
    input  logic [9:0]           i_col,
    input  logic [9:0]           i_row,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output lepp_pkg::t_item      o_q_item
);
    lepp_pkg::t_item r_q [2];
    logic [0:0] r_wp, r_rp;
    logic [1:0] r_cnt;
    lepp_pkg::t_item w_item;
    logic w_push;

    always_comb begin
        w_item.frame_start = i_frame_start;
        w_item.label = i_label;
        w_item.col = i_col;
        w_item.row = i_row;
        if ((i_label >= 4'd1 && i_label <= 4'd4) || i_label == 4'd11) begin
            w_item.edge_ok = (i_right_label != i_label);
        end else if (i_label >= 4'd5 && {28'd0, i_label} < 32'(NUM_CLASSES)) begin
            w_item.edge_ok = (i_left_label != i_label);
        end else begin
            w_item.edge_ok = 1'b0;
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

>>> sv/lepp_div.sv
// Restoring divider for the projection quotients, one quotient bit per cycle.
module lepp_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [63:0]  i_num,
    input  logic signed [63:0]  i_den,
    output logic                o_done,
    output logic signed [63:0]  o_quo
);
    logic [63:0] r_n, r_d, r_q;
    logic [64:0] r_rem;
    logic        r_neg, r_busy;
    logic [6:0]  r_cnt;
    logic [64:0] w_sh;
    logic [64:0] w_sub;

    assign w_sh  = {r_rem[63:0], r_n[63]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n <= i_num[63] ? 64'(-i_num) : i_num;
                r_d <= i_den[63] ? 64'(-i_den) : i_den;
                r_neg <= i_num[63] ^ i_den[63];
                r_rem <= '0;
                r_q <= '0;
                r_cnt <= 7'd64;
            end else if (r_busy) begin
                r_n <= {r_n[62:0], 1'b0};
                if (!w_sub[64]) begin
                    r_rem <= w_sub;
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

>>> sv/lepp_back.sv
// Back part: scale, project, divide, range filter, per-class acceptance.
module lepp_back #(
    parameter int MAP_WIDTH   = lepp_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT  = lepp_pkg::MAP_HEIGHT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  lepp_pkg::t_item      i_q_item,
    input  logic [62:0]          i_hom0,
    input  logic [62:0]          i_hom1,
    input  logic [62:0]          i_hom2,
    input  logic [14:0]          i_max_fwd,
    input  logic [7:0]           i_min_pts,
    input  logic [11:0]          i_roi_w,
    input  logic [11:0]          i_roi_h,
    input  logic [11:0]          i_roi_s,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [3:0]           o_lane_class,
    output logic [14:0]          o_forward_x,
    output logic signed [11:0]   o_lateral_y,
    output logic [11:0]          o_image_u,
    output logic [12:0]          o_image_v
);
    // Reciprocals of the map size, exact for every 22-bit scaled product.
    localparam int          SCL_W    = 22;
    localparam int          U_SH     = SCL_W + $clog2(MAP_WIDTH);
    localparam int          V_SH     = SCL_W + $clog2(MAP_HEIGHT);
    localparam logic [23:0] U_RECIP  = 24'(((64'd1 << U_SH) / 64'(MAP_WIDTH)) + 64'd1);
    localparam logic [23:0] V_RECIP  = 24'(((64'd1 << V_SH) / 64'(MAP_HEIGHT)) + 64'd1);

    lepp_pkg::t_state r_st, n_st;
    lepp_pkg::t_item  r_it;
    logic [21:0] r_pu, r_pv;
    logic [11:0] r_u;
    logic [12:0] r_v;
    logic signed [63:0] r_p0, r_p1, r_p2, r_fwd, r_lat;
    logic [1:0]  r_step;
    logic        r_sel;
    logic [7:0]  r_cnt [16];
    logic signed [11:0] r_last [16];

    logic [45:0] w_uprod, w_vprod;
    logic [21:0] w_uq, w_vq;
    logic [22:0] w_v;
    logic signed [63:0] w_prod_a, w_prod_b;
    logic        w_div_start, w_div_done;
    logic signed [63:0] w_quo;
    logic signed [12:0] w_diff;
    logic [12:0] w_adiff;
    logic [7:0]  w_cnt_now;
    logic        w_range_ok, w_take, w_keep;

    lepp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num((r_st == lepp_pkg::ST_DIV) ? (r_p1 <<< 6) : (r_p0 <<< 6)), .i_den(r_p2),
        .o_done(w_div_done), .o_quo(w_quo)
    );

    // divide by the map size through a reciprocal multiply and shift
    assign w_uprod = {24'd0, r_pu} * {22'd0, U_RECIP};
    assign w_vprod = {24'd0, r_pv} * {22'd0, V_RECIP};
    assign w_uq = 22'(w_uprod >> U_SH);
    assign w_vq = 22'(w_vprod >> V_SH);
    assign w_v  = {1'b0, w_vq} + {11'd0, i_roi_s};

    always_comb begin
        case (r_step)
            2'd0: begin
                w_prod_a = 64'(lepp_pkg::coef(i_hom0, 0)) * $signed({52'd0, r_u});
                w_prod_b = 64'(lepp_pkg::coef(i_hom0, 1)) * $signed({51'd0, r_v});
            end
            2'd1: begin
                w_prod_a = 64'(lepp_pkg::coef(i_hom1, 0)) * $signed({52'd0, r_u});
                w_prod_b = 64'(lepp_pkg::coef(i_hom1, 1)) * $signed({51'd0, r_v});
            end
            default: begin
                w_prod_a = 64'(lepp_pkg::coef(i_hom2, 0)) * $signed({52'd0, r_u});
                w_prod_b = 64'(lepp_pkg::coef(i_hom2, 1)) * $signed({51'd0, r_v});
            end
        endcase
    end

    assign w_cnt_now = r_it.frame_start ? 8'd0 : r_cnt[r_it.label];
    assign w_diff  = 13'(r_lat) - 13'(r_last[r_it.label]);
    assign w_adiff = w_diff[12] ? 13'(-w_diff) : 13'(w_diff);
    assign w_range_ok = (r_fwd >= 0) && (r_fwd <= $signed({49'd0, i_max_fwd}))
                     && (r_lat <= 64'(lepp_pkg::LAT_LIMIT))
                     && (r_lat >= -64'(lepp_pkg::LAT_LIMIT));
    assign w_take = w_range_ok && ((w_cnt_now < i_min_pts)
                     || (r_fwd < 64'(lepp_pkg::FWD_NEAR)) || (w_adiff < lepp_pkg::LAT_STEP));
    assign w_keep = r_it.edge_ok && (r_p2 != 0) && w_take;

    always_comb begin
        n_st = r_st;
        o_q_pop = 1'b0;
        w_div_start = 1'b0;
        case (r_st)
            lepp_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_st = lepp_pkg::ST_SCALE;
                end
            end
            lepp_pkg::ST_SCALE: begin
                n_st = r_it.edge_ok ? lepp_pkg::ST_PROJ : lepp_pkg::ST_CHECK;
            end
            lepp_pkg::ST_PROJ: begin
                if (r_step == 2'd3) begin
                    if (r_p2 == 0) begin
                        n_st = lepp_pkg::ST_CHECK;
                    end else begin
                        w_div_start = 1'b1;
                        n_st = lepp_pkg::ST_DIV;
                    end
                end
            end
            lepp_pkg::ST_DIV: begin
                if (w_div_done) begin
                    if (!r_sel) w_div_start = 1'b1;
                    else n_st = lepp_pkg::ST_CHECK;
                end
            end
            lepp_pkg::ST_CHECK: begin
                n_st = w_keep ? lepp_pkg::ST_OUT : lepp_pkg::ST_IDLE;
            end
            lepp_pkg::ST_OUT: begin
                if (!o_valid || i_ready) n_st = lepp_pkg::ST_IDLE;
            end
            default: n_st = lepp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= lepp_pkg::ST_IDLE;
            o_valid <= 1'b0;
            for (int k = 0; k < 16; k++) r_cnt[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == lepp_pkg::ST_OUT && (!o_valid || i_ready)) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
            case (r_st)
                lepp_pkg::ST_IDLE: begin
                    if (i_q_valid) begin
                        r_it <= i_q_item;
                        r_pu <= 22'(i_q_item.col) * 22'(i_roi_w);
                        r_pv <= 22'(i_q_item.row) * 22'(i_roi_h);
                        r_step <= 2'd0;
                        r_sel <= 1'b0;
                        r_p2 <= '0;
                    end
                end
                lepp_pkg::ST_SCALE: begin
                    r_u <= (w_uq > 22'd4095) ? 12'd4095 : w_uq[11:0];
                    r_v <= (w_v > 23'd8191) ? 13'd8191 : w_v[12:0];
                end
                lepp_pkg::ST_PROJ: begin
                    if (r_step != 2'd3) begin
                        r_step <= r_step + 2'd1;
                        case (r_step)
                            2'd0: r_p0 <= w_prod_a + w_prod_b
                                         + 64'(lepp_pkg::coef(i_hom0, 2));
                            2'd1: r_p1 <= w_prod_a + w_prod_b
                                         + 64'(lepp_pkg::coef(i_hom1, 2));
                            default: r_p2 <= w_prod_a + w_prod_b
                                         + 64'(lepp_pkg::coef(i_hom2, 2));
                        endcase
                    end
                end
                lepp_pkg::ST_DIV: begin
                    if (w_div_done) begin
                        if (!r_sel) r_fwd <= w_quo;
                        else r_lat <= w_quo;
                        r_sel <= 1'b1;
                    end
                end
                lepp_pkg::ST_CHECK: begin
                    // clear counts on frame start even when the pixel is dropped
                    for (int k = 0; k < 16; k++) begin
                        if (w_keep && r_it.label == 4'(k)) begin
                            r_cnt[k] <= (w_cnt_now == 8'hFF) ? w_cnt_now
                                                             : w_cnt_now + 8'd1;
                        end else if (r_it.frame_start) begin
                            r_cnt[k] <= '0;
                        end
                    end
                    if (w_keep) begin
                        r_last[r_it.label] <= r_lat[11:0];
                    end
                end
                lepp_pkg::ST_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_lane_class <= r_it.label;
                        o_forward_x <= r_fwd[14:0];
                        o_lateral_y <= r_lat[11:0];
                        o_image_u <= r_u;
                        o_image_v <= r_v;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

>>> sv/lane_edge_point_projector.sv
// Lane edge point projector: config registers, front queue and back engine.
// The engine takes one pixel at a time: an edge pixel runs through scaling, projection and the
// two 64-step divides (forward, then lateral) before the check; a zero denominator skips the
// divides, a non-edge pixel goes from scaling straight to the check, and a dropped one skips output.
// A result held by the receiver stalls the engine; the two-entry queue takes beats until full.
// Reset: synchronous active low; clears counts and queue, loads register defaults.
module lane_edge_point_projector #(
    parameter int MAP_WIDTH   = lepp_pkg::MAP_WIDTH_DEF,
    parameter int MAP_HEIGHT  = lepp_pkg::MAP_HEIGHT_DEF,
    parameter int NUM_CLASSES = lepp_pkg::NUM_CLASSES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [62:0]         i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_frame_start,
    input  logic [3:0]          i_label,
    input  logic [3:0]          i_left_label,
    input  logic [3:0]          i_right_label,
    input  logic [9:0]          i_col,
    input  logic [9:0]          i_row,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [3:0]          o_lane_class,
    output logic [14:0]         o_forward_x,
    output logic signed [11:0]  o_lateral_y,
    output logic [11:0]         o_image_u,
    output logic [12:0]         o_image_v
);
    logic [62:0] r_hom0, r_hom1, r_hom2;
    logic [14:0] r_max_fwd;
    logic [7:0]  r_min_pts;
    logic [11:0] r_roi_w, r_roi_h, r_roi_s;
    logic q_valid, q_pop;
    lepp_pkg::t_item q_item;

    // Hold config registers; writes are expected only while the engine is idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hom0 <= '0; r_hom1 <= '0; r_hom2 <= '0;
            r_max_fwd <= lepp_pkg::MAXFWD_RST;
            r_min_pts <= lepp_pkg::MINPTS_RST;
            r_roi_w <= lepp_pkg::ROIW_RST;
            r_roi_h <= lepp_pkg::ROIH_RST;
            r_roi_s <= lepp_pkg::ROIS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lepp_pkg::REG_HOM0:   r_hom0 <= i_cfg_data;
                lepp_pkg::REG_HOM1:   r_hom1 <= i_cfg_data;
                lepp_pkg::REG_HOM2:   r_hom2 <= i_cfg_data;
                lepp_pkg::REG_MAXFWD: r_max_fwd <= i_cfg_data[14:0];
                lepp_pkg::REG_MINPTS: r_min_pts <= i_cfg_data[7:0];
                lepp_pkg::REG_ROIW:   r_roi_w <= i_cfg_data[11:0];
                lepp_pkg::REG_ROIH:   r_roi_h <= i_cfg_data[11:0];
                lepp_pkg::REG_ROIS:   r_roi_s <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Front: classify each beat and queue it.
    lepp_front #(.NUM_CLASSES(NUM_CLASSES)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_frame_start(i_frame_start), .i_label(i_label),
        .i_left_label(i_left_label), .i_right_label(i_right_label),
        .i_col(i_col), .i_row(i_row),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    // Back: project, filter, and drive the result register.
    lepp_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .i_hom0(r_hom0), .i_hom1(r_hom1), .i_hom2(r_hom2),
        .i_max_fwd(r_max_fwd), .i_min_pts(r_min_pts),
        .i_roi_w(r_roi_w), .i_roi_h(r_roi_h), .i_roi_s(r_roi_s),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_lane_class(o_lane_class), .o_forward_x(o_forward_x),
        .o_lateral_y(o_lateral_y), .o_image_u(o_image_u), .o_image_v(o_image_v)
    );

    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lane_class >= 4'd1 && {28'd0, o_lane_class} < 32'(NUM_CLASSES)))
        else $error("result class out of range");
    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
    a_lat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lateral_y <= 12'sd1920 && o_lateral_y >= -12'sd1920))
        else $error("lateral out of range");
endmodule
